FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the fill engine.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion that also holds during reset
`define ASSERT_CLK_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

FILE: design/arfe_pkg.sv
// Package for the alpha blended rectangle fill engine: field widths,
// command, status and register codes. No dependencies.
package arfe_pkg;

	// Framebuffer size defaults
	localparam int FB_WIDTH_DEF  = 1024;
	localparam int FB_HEIGHT_DEF = 768;

	// Field widths
	localparam int FUNC_W   = 2;
	localparam int XPOS_W   = 10;
	localparam int YPOS_W   = 10;
	localparam int RW_W     = 11;
	localparam int RH_W     = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 20;
	localparam int PIX_W    = 24;
	localparam int CHAN_W   = 8;
	localparam int CFG_IDX_W = 2;

	// Coordinate width for sums and bound checks (frame sides up to 8191)
	localparam int COORD_W = 13;

	// Command codes
	localparam logic [FUNC_W-1:0] FN_FILL    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_OUTLINE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ    = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SKIP   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd3;

endpackage

FILE: design/arfe_blend.sv
// Shared channel arithmetic: per channel (src*factor)>>8 + addend.
// Depends on arfe_pkg. Used both to premultiply the colour and to blend pixels.
module arfe_blend (
	input  logic [arfe_pkg::PIX_W-1:0]  src,
	input  logic [arfe_pkg::CHAN_W-1:0] factor,
	input  logic [arfe_pkg::PIX_W-1:0]  addend,
	output logic [arfe_pkg::PIX_W-1:0]  result
);
	import arfe_pkg::*;

	// Three independent 8x8 products, scaled and offset
	always_comb begin
		logic [2*CHAN_W-1:0] prod;
		for (int c = 0; c < 3; c++) begin
			prod = src[c*CHAN_W +: CHAN_W] * factor;
			result[c*CHAN_W +: CHAN_W] = prod[2*CHAN_W-1:CHAN_W] + addend[c*CHAN_W +: CHAN_W];
		end
	end

endmodule

FILE: design/arfe_fb.sv
// Framebuffer memory: one write port, one read port with registered data.
// Depends on arfe_pkg for the pixel width.
module arfe_fb #(
	parameter int DEPTH = arfe_pkg::FB_WIDTH_DEF * arfe_pkg::FB_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [arfe_pkg::PIX_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [arfe_pkg::PIX_W-1:0] rdata
);
	import arfe_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/alpha_rect_fill_engine.sv
// Alpha blended rectangle fill engine over a FB_WIDTH x FB_HEIGHT framebuffer
// of 24-bit RGB pixels. After reset the block clears the framebuffer, one pixel
// a cycle, with in_stall high; configuration writes are taken throughout. A
// draw command walks one segment for a fill and up to four (top, bottom, left,
// right) for an outline. Pixels stream through the single memory read port at
// one per cycle, the blend unit writing each back the cycle after its read. A
// pixel read goes from evaluation through address setup, read issue and data
// capture to finish; a rejected or skipped command goes from evaluation straight
// to finish. The next command is accepted as soon as the result sits in the
// output register.
module alpha_rect_fill_engine #(
	parameter int FB_WIDTH  = arfe_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT = arfe_pkg::FB_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wen,
	input  logic [arfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arfe_pkg::CHAN_W-1:0]    cfg_data,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [arfe_pkg::FUNC_W-1:0]    func,
	input  logic [arfe_pkg::XPOS_W-1:0]    x_pos,
	input  logic [arfe_pkg::YPOS_W-1:0]    y_pos,
	input  logic [arfe_pkg::RW_W-1:0]      rect_width,
	input  logic [arfe_pkg::RH_W-1:0]      rect_height,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [arfe_pkg::STATUS_W-1:0]  status,
	output logic [arfe_pkg::COUNT_W-1:0]   pixel_count,
	output logic [arfe_pkg::PIX_W-1:0]     pixel_value
);
	import arfe_pkg::*;

	localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW + COORD_W;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_EVAL  = 9'b000000100,
		S_SETUP = 9'b000001000,
		S_BASE  = 9'b000010000,
		S_RUN   = 9'b000100000,
		S_RDISS = 9'b001000000,
		S_RDDAT = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CHAN_W-1:0] red_q, green_q, blue_q, alpha_q;

	// command registers
	logic [FUNC_W-1:0] func_q;
	logic [XPOS_W-1:0] x_q;
	logic [YPOS_W-1:0] y_q;
	logic [RW_W-1:0]   w_q;
	logic [RH_W-1:0]   h_q;

	// segment and walk registers
	logic [2:0]         seg_q;
	logic [COORD_W-1:0] seg_x_q, seg_y_q;
	logic [RW_W-1:0]    seg_w_q, col_q;
	logic [RH_W-1:0]    seg_h_q, row_q;
	logic [AW-1:0]      addr_q, row_base_q, clr_q;

	// blend operands
	logic [PIX_W-1:0]  prem_q;
	logic [CHAN_W-1:0] inv_q;

	// pixel pipeline
	logic          rd_valid_s1;
	logic [AW-1:0] addr_s1;

	// result
	logic [STATUS_W-1:0] status_q, out_status_q;
	logic [COUNT_W-1:0]  count_q, out_count_q;
	logic [PIX_W-1:0]    value_q, out_value_q;
	logic                out_valid_q;

	// memory and unit wiring
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr;
	logic [PIX_W-1:0] mem_wdata, mem_rdata;
	logic [PIX_W-1:0] bl_src, bl_add, bl_out;
	logic [CHAN_W-1:0] bl_factor;

	// checks on the held command
	logic [COORD_W-1:0] x_end, y_end;
	logic               empty_rect, oob_rect, read_in;
	logic               last_col, last_row, out_free;

	assign x_end      = COORD_W'(x_q) + COORD_W'(w_q);
	assign y_end      = COORD_W'(y_q) + COORD_W'(h_q);
	assign empty_rect = (w_q == '0) || (h_q == '0);
	assign oob_rect   = (x_end > COORD_W'(FB_WIDTH)) || (y_end > COORD_W'(FB_HEIGHT));
	assign read_in    = (COORD_W'(x_q) < COORD_W'(FB_WIDTH)) &&
			(COORD_W'(y_q) < COORD_W'(FB_HEIGHT));
	assign last_col   = (col_q == seg_w_q - RW_W'(1));
	assign last_row   = (row_q == seg_h_q - RH_W'(1));
	assign out_free   = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			alpha_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_RED:   red_q   <= cfg_data;
				CFG_GREEN: green_q <= cfg_data;
				CFG_BLUE:  blue_q  <= cfg_data;
				CFG_ALPHA: alpha_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// shared unit: premultiply while evaluating, blend while pixels stream
	always_comb begin
		if (state_q == S_EVAL) begin
			bl_src    = {red_q, green_q, blue_q};
			bl_factor = alpha_q;
			bl_add    = '0;
		end else begin
			bl_src    = mem_rdata;
			bl_factor = inv_q;
			bl_add    = prem_q;
		end
	end

	arfe_blend u_blend (
		.src    (bl_src),
		.factor (bl_factor),
		.addend (bl_add),
		.result (bl_out)
	);

	// memory port selection: clearing sweep or pixel write-back
	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = rd_valid_s1;
			mem_waddr = addr_s1;
			mem_wdata = bl_out;
		end
	end
	assign mem_re = (state_q == S_RUN) || (state_q == S_RDISS);

	arfe_fb #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_fb (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// pipeline stage between read and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_RUN);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
	end

	// result handshake: loaded on finish, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (func_q == FN_READ) begin
						state_q <= read_in ? S_BASE : S_FIN;
					end else if (func_q == FN_FILL || func_q == FN_OUTLINE) begin
						state_q <= (empty_rect || oob_rect || alpha_q == '0) ? S_FIN : S_SETUP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SETUP: begin
					if (func_q == FN_FILL) begin
						state_q <= (seg_q == 3'd0) ? S_BASE : S_FIN;
					end else begin
						case (seg_q)
							3'd0:    state_q <= S_BASE;
							3'd1:    state_q <= (h_q > RH_W'(1)) ? S_BASE : S_FIN;
							3'd2:    state_q <= (h_q > RH_W'(2)) ? S_BASE : S_FIN;
							3'd3:    state_q <= (h_q > RH_W'(2) && w_q > RW_W'(1)) ?
									S_BASE : S_FIN;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_BASE: begin
					state_q <= (func_q == FN_READ) ? S_RDISS : S_RUN;
				end
				S_RUN: begin
					if (last_col && last_row) begin
						state_q <= S_SETUP;
					end
				end
				S_RDISS: state_q <= S_RDDAT;
				S_RDDAT: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				func_q <= func;
				x_q    <= x_pos;
				y_q    <= y_pos;
				w_q    <= rect_width;
				h_q    <= rect_height;
			end
			S_EVAL: begin
				prem_q  <= bl_out;
				inv_q   <= ~alpha_q;
				count_q <= '0;
				value_q <= '0;
				seg_q   <= '0;
				seg_x_q <= COORD_W'(x_q);
				seg_y_q <= COORD_W'(y_q);
				if (func_q == FN_READ) begin
					status_q <= read_in ? ST_DONE : ST_REJECT;
				end else if (func_q == FN_FILL || func_q == FN_OUTLINE) begin
					if (empty_rect) begin
						status_q <= ST_SKIP;
					end else if (oob_rect) begin
						status_q <= ST_REJECT;
					end else if (alpha_q == '0) begin
						status_q <= ST_SKIP;
					end else begin
						status_q <= ST_DONE;
					end
				end else begin
					status_q <= ST_SKIP;
				end
			end
			S_SETUP: begin
				seg_q <= seg_q + 3'd1;
				// segment geometry: full area, or top, bottom, left, right
				if (func_q == FN_FILL) begin
					seg_x_q <= COORD_W'(x_q);
					seg_y_q <= COORD_W'(y_q);
					seg_w_q <= w_q;
					seg_h_q <= h_q;
				end else begin
					case (seg_q)
						3'd0: begin
							seg_x_q <= COORD_W'(x_q);
							seg_y_q <= COORD_W'(y_q);
							seg_w_q <= w_q;
							seg_h_q <= RH_W'(1);
						end
						3'd1: begin
							seg_x_q <= COORD_W'(x_q);
							seg_y_q <= y_end - COORD_W'(1);
							seg_w_q <= w_q;
							seg_h_q <= RH_W'(1);
						end
						3'd2: begin
							seg_x_q <= COORD_W'(x_q);
							seg_y_q <= COORD_W'(y_q) + COORD_W'(1);
							seg_w_q <= RW_W'(1);
							seg_h_q <= h_q - RH_W'(2);
						end
						default: begin
							seg_x_q <= x_end - COORD_W'(1);
							seg_y_q <= COORD_W'(y_q) + COORD_W'(1);
							seg_w_q <= RW_W'(1);
							seg_h_q <= h_q - RH_W'(2);
						end
					endcase
				end
			end
			S_BASE: begin
				logic [PW-1:0] lin;
				lin = PW'(seg_y_q) * PW'(FB_WIDTH) + PW'(seg_x_q);
				addr_q     <= lin[AW-1:0];
				row_base_q <= lin[AW-1:0];
				col_q      <= '0;
				row_q      <= '0;
			end
			S_RUN: begin
				count_q <= count_q + COUNT_W'(1);
				if (last_col) begin
					col_q      <= '0;
					row_q      <= row_q + RH_W'(1);
					row_base_q <= row_base_q + AW'(FB_WIDTH);
					addr_q     <= row_base_q + AW'(FB_WIDTH);
				end else begin
					col_q  <= col_q + RW_W'(1);
					addr_q <= addr_q + AW'(1);
				end
			end
			S_RDDAT: begin
				value_q <= mem_rdata;
			end
			S_FIN: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_count_q  <= count_q;
					out_value_q  <= value_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign pixel_count = out_count_q;
	assign pixel_value = out_value_q;

endmodule

FILE: design/arfe_checker.sv
// Port-level checks on the fill engine, attached by bind.
// Depends on arfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arfe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [arfe_pkg::STATUS_W-1:0]  status,
	input logic [arfe_pkg::COUNT_W-1:0]   pixel_count,
	input logic [arfe_pkg::PIX_W-1:0]     pixel_value
);
	import arfe_pkg::*;

	// a stalled result stays on offer
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid)

	// one command at a time: busy right after a command is taken
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall)

	// skipped or rejected commands write nothing and return no pixel
	`ASSERT_CLK(a_no_work, clk, arst_n,
		out_valid && status != ST_DONE |-> pixel_count == '0 && pixel_value == '0)

	// no result is offered while reset is held
	`ASSERT_CLK_NR(a_reset_quiet, clk, !arst_n |-> !out_valid)

endmodule

bind alpha_rect_fill_engine arfe_checker u_arfe_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for alpha_rect_fill_engine: fill, outline and read commands
// checked against a predictor with its own copy of the framebuffer.
// Depends on arfe_pkg and the alpha_rect_fill_engine RTL only.
`timescale 1ns / 1ps

module testbench;
	import arfe_pkg::*;

	localparam int FB_W           = FB_WIDTH_DEF;
	localparam int FB_H           = FB_HEIGHT_DEF;
	localparam int FB_PIXELS      = FB_W * FB_H;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int RAND_PHASES    = 11;
	localparam int PHASE_ITEMS    = 100;
	localparam int LONG_HOLD      = 600;
	localparam int TAIL_CYCLES    = 50;
	localparam int MAX_REPORTS    = 10;
	// clearing pass plus worst-case drawing, several times over
	localparam longint TIMEOUT_NS = 80_000_000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [XPOS_W-1:0] x;
		logic [YPOS_W-1:0] y;
		logic [RW_W-1:0]   w;
		logic [RH_W-1:0]   h;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [PIX_W-1:0]    value;
	} result_t;

	// Predicts each command against its own framebuffer and checks results in order
	class fill_scoreboard;
		bit [PIX_W-1:0]  frame [FB_PIXELS];
		bit [CHAN_W-1:0] red, green, blue, alpha;
		result_t         expected_q[$];
		int              fail_count;

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] val);
			case (idx)
				CFG_RED:   red   = val;
				CFG_GREEN: green = val;
				CFG_BLUE:  blue  = val;
				CFG_ALPHA: alpha = val;
				default: ;
			endcase
		endfunction

		// Per-channel blend; the sum stays within 8 bits so nothing spills
		function bit [CHAN_W-1:0] blend_channel(bit [CHAN_W-1:0] old, bit [CHAN_W-1:0] col);
			bit [15:0] p, keep;
			p = (col * alpha) >> 8;
			if (alpha == 8'hff)
				return p[7:0];
			keep = (old * (16'h00ff - alpha)) >> 8;
			return keep[7:0] + p[7:0];
		endfunction

		// Paints an in-bounds area, returns pixels written
		function int unsigned paint(int unsigned x, int unsigned y, int unsigned w,
				int unsigned h);
			int unsigned row, col, idx, n;
			bit [PIX_W-1:0] old;
			n = 0;
			for (row = 0; row < h; row++) begin
				for (col = 0; col < w; col++) begin
					idx = (y + row) * FB_W + (x + col);
					old = frame[idx];
					frame[idx] = {blend_channel(old[23:16], red),
						blend_channel(old[15:8], green), blend_channel(old[7:0], blue)};
					n++;
				end
			end
			return n;
		endfunction

		function void note_command(cmd_t c);
			result_t r;
			int unsigned x, y, w, h, n;
			x = c.x;
			y = c.y;
			w = c.w;
			h = c.h;
			n = 0;
			r = '0;
			r.status = ST_SKIP;
			if (c.func == FN_READ) begin
				if (x < FB_W && y < FB_H) begin
					r.value  = frame[y * FB_W + x];
					r.status = ST_DONE;
				end else begin
					r.status = ST_REJECT;
				end
			end else if (c.func == FN_FILL || c.func == FN_OUTLINE) begin
				// empty wins over out of bounds, which wins over alpha zero
				if (w == 0 || h == 0)
					r.status = ST_SKIP;
				else if (x + w > FB_W || y + h > FB_H)
					r.status = ST_REJECT;
				else if (alpha == 0)
					r.status = ST_SKIP;
				else begin
					r.status = ST_DONE;
					if (c.func == FN_FILL) begin
						n = paint(x, y, w, h);
					end else begin
						// top, bottom, then the side columns between them
						n = paint(x, y, w, 1);
						if (h > 1)
							n += paint(x, y + h - 1, w, 1);
						if (h > 2) begin
							n += paint(x, y + 1, 1, h - 2);
							if (w > 1)
								n += paint(x + w - 1, y + 1, 1, h - 2);
						end
					end
				end
			end
			r.count = n[COUNT_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void report(string what, result_t want, result_t got);
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%s: expected status %0d count %0d value %06h, got status %0d count %0d value %06h",
					what, want.status, want.count, want.value,
					got.status, got.count, got.value);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report("result with no command outstanding", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.count !== want.count ||
					got.value !== want.value)
				report("result mismatch", want, got);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit failed();
			return fail_count != 0 || expected_q.size() != 0;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CHAN_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [FUNC_W-1:0]    func;
	logic [XPOS_W-1:0]    x_pos;
	logic [YPOS_W-1:0]    y_pos;
	logic [RW_W-1:0]      rect_width;
	logic [RH_W-1:0]      rect_height;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;
	logic [COUNT_W-1:0]   pixel_count;
	logic [PIX_W-1:0]     pixel_value;

	fill_scoreboard sb;
	bit             long_hold_req;

	alpha_rect_fill_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.pixel_count (pixel_count),
		.pixel_value (pixel_value)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#(TIMEOUT_NS);
		$display("testbench: FAIL");
		$finish;
	end

	// Monitors: results checked before the new command is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result('{status, pixel_count, pixel_value});
			if (in_valid && !in_stall)
				sb.note_command('{func, x_pos, y_pos, rect_width, rect_height});
		end
	end

	// Result side stalls: random spans of differing density, plus one long hold-off
	initial begin : stall_pattern
		int mode, span, i;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				for (i = 0; i < LONG_HOLD; i++) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 200);
			for (i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= ($urandom_range(0, 9) < 8);
					default: out_stall <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	function automatic cmd_t cmd(int f, int x, int y, int w, int h);
		cmd_t c;
		c.func = FUNC_W'(f);
		c.x    = XPOS_W'(x);
		c.y    = YPOS_W'(y);
		c.w    = RW_W'(w);
		c.h    = RH_W'(h);
		return c;
	endfunction

	function automatic bit [CHAN_W-1:0] rand_chan();
		return CHAN_W'($urandom_range(0, 255));
	endfunction

	// Mostly small boxes and reads in a busy corner, some at the far edges, some noise
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   pick, w, h;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			c = cmd($urandom_range(0, 1) ? FN_OUTLINE : FN_FILL, $urandom_range(0, 47),
				$urandom_range(0, 31), $urandom_range(1, 16), $urandom_range(1, 16));
		end else if (pick < 80) begin
			c = cmd(FN_READ, $urandom_range(0, 63), $urandom_range(0, 47), 0, 0);
		end else if (pick < 86) begin
			w = $urandom_range(1, 16);
			h = $urandom_range(1, 16);
			c = cmd($urandom_range(0, 1) ? FN_OUTLINE : FN_FILL,
				FB_W - w - $urandom_range(0, 3), FB_H - h - $urandom_range(0, 3), w, h);
		end else if (pick < 90) begin
			c = cmd(FN_READ, $urandom_range(FB_W - 8, FB_W - 1),
				$urandom_range(FB_H - 8, 1023), 0, 0);
		end else begin
			c = cmd($urandom_range(0, 3), $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 2047), $urandom_range(0, 1023));
			// keep big in-bounds fills cheap by turning them into outlines
			if (c.func == FN_FILL && c.x + c.w <= FB_W && c.y + c.h <= FB_H &&
					c.w * c.h > 2048)
				c.func = FN_OUTLINE;
		end
		return c;
	endfunction

	task automatic send_command(cmd_t c);
		@(negedge clk);
		in_valid    <= 1'b1;
		func        <= c.func;
		x_pos       <= c.x;
		y_pos       <= c.y;
		rect_width  <= c.w;
		rect_height <= c.h;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Drops valid and waits for every outstanding result
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		sb.set_register(idx, val);
	endtask

	task automatic set_colour(bit [CHAN_W-1:0] r, bit [CHAN_W-1:0] g, bit [CHAN_W-1:0] b,
			bit [CHAN_W-1:0] a);
		wait_idle();
		write_reg(CFG_RED, r);
		write_reg(CFG_GREEN, g);
		write_reg(CFG_BLUE, b);
		write_reg(CFG_ALPHA, a);
	endtask

	// Bursts of items with random gaps, or back to back when no_idle is set
	task automatic run_random_phase(int n_items, bit no_idle);
		int sent, burst, k;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 12);
			for (k = 0; k < burst && sent < n_items; k++) begin
				send_command(random_cmd());
				sent++;
			end
			if (!no_idle && $urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 90));
		end
	endtask

	// Main sequence
	initial begin : main_seq
		int ph;
		sb            = new();
		long_hold_req = 1'b0;
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		func          = '0;
		x_pos         = '0;
		y_pos         = '0;
		rect_width    = '0;
		rect_height   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset colour: alpha zero draws nothing, framebuffer reads as cleared
		send_command(cmd(FN_READ, 0, 0, 0, 0));
		send_command(cmd(FN_FILL, 0, 0, 4, 4));

		// Opaque overwrite, frame extremes, empty, out-of-bounds and unused-code cases
		set_colour(8'hff, 8'h00, 8'h80, 8'hff);
		send_command(cmd(FN_FILL, 0, 0, 4, 4));
		send_command(cmd(FN_READ, 3, 3, 0, 0));
		send_command(cmd(FN_OUTLINE, 0, 0, FB_W, FB_H));
		send_command(cmd(FN_READ, FB_W - 1, FB_H - 1, 0, 0));
		send_command(cmd(FN_FILL, FB_W - 1, 5, 0, 3));
		send_command(cmd(FN_FILL, 5, 5, 3, 0));
		send_command(cmd(FN_FILL, FB_W - 1, 5, 2, 1));
		send_command(cmd(FN_OUTLINE, 5, FB_H - 1, 1, 2));
		send_command(cmd(FN_FILL, 0, 100, FB_W, 1));
		send_command(cmd(FN_FILL, 1023, 1023, 2047, 1023));
		send_command(cmd(FN_UNUSED, 7, 7, 7, 7));
		send_command(cmd(FN_READ, FB_W - 1, FB_H, 0, 0));
		send_command(cmd(FN_READ, 0, 1023, 0, 0));
		// outline shapes: single row, two rows, single column, full box
		send_command(cmd(FN_OUTLINE, 10, 10, 5, 1));
		send_command(cmd(FN_OUTLINE, 20, 10, 5, 2));
		send_command(cmd(FN_OUTLINE, 30, 10, 1, 6));
		send_command(cmd(FN_OUTLINE, 40, 10, 6, 6));

		// Half blend over the opaque box
		set_colour(8'd200, 8'd100, 8'd50, 8'd128);
		send_command(cmd(FN_FILL, 0, 0, 8, 8));
		send_command(cmd(FN_READ, 2, 2, 0, 0));

		// Alpha zero: in bounds skips, out of bounds still rejects
		set_colour(8'h00, 8'hff, 8'hff, 8'h00);
		send_command(cmd(FN_FILL, 0, 0, 8, 8));
		send_command(cmd(FN_FILL, FB_W - 4, 0, 8, 1));

		// Alpha just above zero and just below opaque
		set_colour(8'hff, 8'hff, 8'hff, 8'd1);
		send_command(cmd(FN_FILL, 1, 1, 2, 2));
		set_colour(8'hff, 8'hff, 8'hff, 8'd254);
		send_command(cmd(FN_FILL, 1, 1, 2, 2));
		send_command(cmd(FN_READ, 1, 1, 0, 0));

		// Random phases, each under its own colour
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: set_colour(8'h00, 8'h00, 8'h00, 8'hff);
				1: set_colour(8'hff, 8'hff, 8'hff, 8'd1);
				2: set_colour(rand_chan(), rand_chan(), rand_chan(), 8'd254);
				3: set_colour(rand_chan(), rand_chan(), rand_chan(), 8'h00);
				default: set_colour(rand_chan(), rand_chan(), rand_chan(), rand_chan());
			endcase
			// long receiver hold-off while items keep coming
			if (ph == 2)
				long_hold_req = 1'b1;
			run_random_phase(PHASE_ITEMS, ph == 2 || ph == 6);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.failed())
			$display("testbench: FAIL");
		else
			$display("testbench: PASS");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/arfe_pkg.sv
design/arfe_blend.sv
design/arfe_fb.sv
design/alpha_rect_fill_engine.sv
design/arfe_checker.sv
sim/testbench.sv
